FILE: sv/assert_macros.svh
// assertion macros shared by the keypad countdown timer modules
// no dependencies; bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// full property, may use |-> or |=>
`define KCT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("kct assertion failed");
// antecedent implies consequent in the same cycle
`define KCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kct implication failed");
`else
`define KCT_ASSERT(lbl, clk, rst_n, prop)
`define KCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/kct_pkg.sv
// types, codes and tables of the keypad countdown timer
// no dependencies
package kct_pkg;

	// event kinds
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_KEY  = 1'b1;

	// decoded key codes beyond the digits
	localparam logic [3:0] KEY_CLEAR = 4'd10;
	localparam logic [3:0] KEY_START = 4'd11;
	localparam logic [3:0] KEY_NONE  = 4'd15;

	localparam logic [3:0] SEC_TENS_MAX = 4'd5;
	localparam logic [3:0] DIGIT_MAX    = 4'd9;
	localparam logic [7:0] COLON_BIT    = 8'h10;

	// timer state, digits[0] is seconds ones and digits[3] minutes tens
	typedef struct packed {
		logic [3:0][3:0] digits;
		logic            running;
		logic            finished;
	} kct_state_t;

	localparam kct_state_t STATE_RESET = '0;

	// keypad: row0 = 1 2 3, row1 = 4 5 6, row2 = 7 8 9, row3 = * 0 #
	function automatic logic [3:0] key_decode(input logic [1:0] row, input logic [1:0] col);
		logic [3:0] key;
		key = KEY_NONE;
		if (col != 2'd3) begin
			if (row == 2'd3) begin
				case (col)
					2'd0:    key = KEY_CLEAR;
					2'd1:    key = 4'd0;
					2'd2:    key = KEY_START;
					default: key = KEY_NONE;
				endcase
			end else begin
				key = 4'({2'b00, row} * 4'd3 + {2'b00, col} + 4'd1);
			end
		end
		return key;
	endfunction

	// seven-segment byte of one digit, blank for non-digits
	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0:    s = 8'b11101110;
			4'd1:    s = 8'b00101000;
			4'd2:    s = 8'b10100111;
			4'd3:    s = 8'b10101101;
			4'd4:    s = 8'b01101001;
			4'd5:    s = 8'b11001101;
			4'd6:    s = 8'b01001111;
			4'd7:    s = 8'b10101000;
			4'd8:    s = 8'b11101111;
			4'd9:    s = 8'b11101001;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

FILE: sv/kct_next.sv
// next-state logic of the timer for one tick or key item
// depends on kct_pkg
module kct_next (
	input  kct_pkg::kct_state_t state,
	input  logic                opcode,
	input  logic [1:0]          key_row,
	input  logic [1:0]          key_column,
	output kct_pkg::kct_state_t state_nxt
);
	import kct_pkg::*;

	logic [3:0] key;
	kct_state_t tick_st;
	kct_state_t key_st;

	assign key = key_decode(key_row, key_column);

	// running tick: decrement with borrow chain
	always_comb begin
		tick_st = state;
		if (state.running) begin
			tick_st.digits[0] = state.digits[0] - 4'd1;
			if (tick_st.digits == '0) begin
				tick_st.digits   = {4'd2, 4'd0, 4'd1, 4'd3};
				tick_st.running  = 1'b0;
				tick_st.finished = 1'b1;
			end
			if (tick_st.digits[0] > DIGIT_MAX) begin
				tick_st.digits[0] = DIGIT_MAX;
				tick_st.digits[1] = tick_st.digits[1] - 4'd1;
			end
			if (tick_st.digits[1] > SEC_TENS_MAX) begin
				tick_st.digits[1] = SEC_TENS_MAX;
				tick_st.digits[2] = tick_st.digits[2] - 4'd1;
			end
			if (tick_st.digits[2] > DIGIT_MAX) begin
				tick_st.digits[2] = DIGIT_MAX;
				tick_st.digits[3] = tick_st.digits[3] - 4'd1;
			end
			if (tick_st.digits[3] > DIGIT_MAX) begin
				tick_st.digits[3] = DIGIT_MAX;
			end
		end
	end

	// key press: clear always, others only while stopped
	always_comb begin
		key_st = state;
		if (key == KEY_CLEAR) begin
			key_st = STATE_RESET;
		end else if (key != KEY_NONE && !state.running) begin
			if (state.finished) begin
				key_st.finished = 1'b0;
				key_st.digits   = '0;
			end
			if (key == KEY_START) begin
				key_st.running = 1'b1;
			end else begin
				key_st.digits = {key_st.digits[2:0], key};
			end
		end
	end

	assign state_nxt = (opcode == OP_KEY) ? key_st : tick_st;

endmodule

FILE: sv/kct_outbuf.sv
// two-entry result buffer: head register plus skid register
// depends on kct_pkg and assert_macros.svh
`include "assert_macros.svh"
module kct_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  kct_pkg::kct_state_t din,
	output logic                full,
	output logic                head_valid,
	input  logic                pop_ready,
	output kct_pkg::kct_state_t head
);
	import kct_pkg::*;

	kct_state_t head_q;
	kct_state_t skid_q;
	logic       head_valid_q;
	logic       skid_valid_q;
	logic       pop;

	assign pop        = head_valid_q && pop_ready;
	assign full       = skid_valid_q;
	assign head_valid = head_valid_q;
	assign head       = head_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				head_valid_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= din;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_q <= din;
			end else begin
				head_q <= din;
			end
		end
	end

	`KCT_ASSERT_IMPL(a_skid_needs_head, clk, arst_n, skid_valid_q, head_valid_q)
	`KCT_ASSERT(a_stalled_push_to_skid, clk, arst_n, (push && head_valid_q && !pop) |=> skid_valid_q)
	`KCT_ASSERT(a_head_kept_on_stall, clk, arst_n, (head_valid_q && !pop_ready) |=> head_valid_q)

endmodule

FILE: sv/keypad_countdown_timer.sv
// top level of the keypad countdown timer (MM:SS, four BCD digits)
// depends on kct_pkg, kct_next, kct_outbuf and assert_macros.svh
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | opcode, key_row, key_column
//  out     | out_valid / out_ready| digits, is_running, is_finished, segments
//
// one item per cycle while in_ready is high; each result is registered into the buffer's head or skid register.
// the state update is a single combinational pass between the state register
// and a two-entry result buffer.
// in_ready drops only while the buffer holds two results not yet taken.
// reset clears the digits and both flags and empties the result buffer.
`include "assert_macros.svh"
module keypad_countdown_timer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [1:0] key_row,
	input  logic [1:0] key_column,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] minutes_tens,
	output logic [3:0] minutes_ones,
	output logic [2:0] seconds_tens,
	output logic [3:0] seconds_ones,
	output logic       is_running,
	output logic       is_finished,
	output logic [7:0] segments_low_digit,
	output logic [7:0] segments_second_digit,
	output logic [7:0] segments_third_digit,
	output logic [7:0] segments_high_digit
);
	import kct_pkg::*;

	kct_state_t state_q;
	kct_state_t state_nxt;
	kct_state_t res;
	logic       in_accept;
	logic       buf_full;
	logic [7:0] colon;

	assign in_ready  = !buf_full;
	assign in_accept = in_valid && in_ready;

	// next-state logic for the incoming item
	kct_next u_next (
		.state      (state_q),
		.opcode     (opcode),
		.key_row    (key_row),
		.key_column (key_column),
		.state_nxt  (state_nxt)
	);

	// timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (in_accept) begin
			state_q <= state_nxt;
		end
	end

	// result buffer holds the state after each item
	kct_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_accept),
		.din        (state_nxt),
		.full       (buf_full),
		.head_valid (out_valid),
		.pop_ready  (out_ready),
		.head       (res)
	);

	// display fields and segment bytes
	assign colon        = res.finished ? 8'h00 : COLON_BIT;
	assign minutes_tens = res.digits[3];
	assign minutes_ones = res.digits[2];
	assign seconds_tens = (res.digits[1] > SEC_TENS_MAX) ? SEC_TENS_MAX[2:0]
	                                                     : res.digits[1][2:0];
	assign seconds_ones = res.digits[0];
	assign is_running   = res.running;
	assign is_finished  = res.finished;
	assign segments_low_digit    = seg_of(res.digits[0]);
	assign segments_second_digit = seg_of(res.digits[1]) | colon;
	assign segments_third_digit  = seg_of(res.digits[2]) | colon;
	assign segments_high_digit   = seg_of(res.digits[3]);

	`KCT_ASSERT_IMPL(a_not_run_and_fin, clk, arst_n, state_q.running, !state_q.finished)
	`KCT_ASSERT_IMPL(a_digits_bcd, clk, arst_n, 1'b1, (state_q.digits[0] <= DIGIT_MAX) && (state_q.digits[1] <= DIGIT_MAX) && (state_q.digits[2] <= DIGIT_MAX) && (state_q.digits[3] <= DIGIT_MAX))
	`KCT_ASSERT(a_idle_tick_holds, clk, arst_n, (in_accept && opcode == OP_TICK && !state_q.running) |=> (state_q == $past(state_q)))

endmodule
